// File: sv/pacc_pkg.sv
`default_nettype none

package pacc_pkg;

  // Widest slot index the parameter range can reach: 16 ports of 32 pins.
  localparam int unsigned SLOT_MAX_W = 9;

  // Operation codes.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Pin mode codes.
  localparam logic [1:0] MODE_INPUT  = 2'd0;
  localparam logic [1:0] MODE_OUTPUT = 2'd1;
  localparam logic [1:0] MODE_ALT    = 2'd2;
  localparam logic [1:0] MODE_ANALOG = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;

  // Width of the settings fields that are compared outside AF mode.
  localparam int unsigned BASE_SET_W = 7;

  typedef logic [SLOT_MAX_W-1:0] slot_t;

  // One incoming request.
  typedef struct packed {
    logic        operation;
    logic [3:0]  port_index;
    logic [4:0]  pin_index;
    logic [1:0]  pin_mode;
    logic        output_type;
    logic [1:0]  output_speed;
    logic [1:0]  pull_select;
    logic [15:0] alt_function_word;
  } req_t;

  // One result.
  typedef struct packed {
    logic [1:0] status;
    logic       apply_now;
  } resp_t;

  // Stored pin settings, 23 bits, mode in the low bits.
  typedef struct packed {
    logic [15:0] af;
    logic [1:0]  pull;
    logic [1:0]  speed;
    logic        otype;
    logic [1:0]  mode;
  } settings_t;

  // Write into the settings store.
  typedef struct packed {
    logic      en;
    slot_t     slot;
    settings_t data;
  } set_wr_t;

  // Update of one ownership bit.
  typedef struct packed {
    logic  en;
    slot_t slot;
    logic  value;
  } own_wr_t;

endpackage

`default_nettype wire

// File: sv/pacc_settings_mem.sv
`default_nettype none

module pacc_settings_mem #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire pacc_pkg::slot_t     rd_slot,
  input  wire pacc_pkg::set_wr_t   wr,
  output pacc_pkg::settings_t      rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pacc_pkg::settings_t mem [DEPTH];
  pacc_pkg::settings_t rd_data_r;
  pacc_pkg::settings_t byp_data_r;
  logic                byp_hit_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot[AW-1:0]] <= wr.data;
    end
  end

  // Registered read port. A write to the same slot in the same cycle is
  // captured alongside so that the reader sees the new settings.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[rd_slot[AW-1:0]];
      byp_hit_r  <= wr.en && (wr.slot == rd_slot);
      byp_data_r <= wr.data;
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : rd_data_r;

endmodule

`default_nettype wire

// File: sv/pacc_owner_bits.sv
`default_nettype none

module pacc_owner_bits #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pacc_pkg::slot_t    rd_slot,
  input  wire pacc_pkg::own_wr_t  wr,
  output logic                    taken
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0] taken_r;
  logic [DEPTH-1:0] taken_nxt;

  // Set or clear one ownership bit.
  always_comb begin
    taken_nxt = taken_r;
    if (wr.en) begin
      taken_nxt[wr.slot[AW-1:0]] = wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= '0;
    end else begin
      taken_r <= taken_nxt;
    end
  end

  assign taken = taken_r[rd_slot[AW-1:0]];

endmodule

`default_nettype wire

// File: sv/pin_allocation_conflict_checker.sv
`default_nettype none

// Pin ownership tracker. Each request either claims or releases one
// (port, pin) pair and gives exactly one result: success, out of range, or
// conflicting settings, with apply_now set only when a claim freshly
// allocates a free pin. Each request is registered, then evaluated into the
// result register. The block takes one request per clock cycle unless a
// stalled result holds the pipeline, though a request is still taken while
// the evaluation stage is empty. The rate is set by the single read port of
// the settings store, read as a request enters and written as the previous
// request completes, with same-slot writes forwarded. Ownership bits are
// flip-flops cleared by reset, so the block is ready right after reset.
module pin_allocation_conflict_checker #(
  parameter int unsigned NUM_PORTS     = 8,
  parameter int unsigned PINS_PER_PORT = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire pacc_pkg::req_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output pacc_pkg::resp_t      out_data
);

  localparam int unsigned NUM_SLOTS = NUM_PORTS * PINS_PER_PORT;

  // Pipeline control.
  logic                 pipe_adv;
  logic                 in_acc;
  logic                 fire;
  logic                 v_r;
  logic                 v_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;

  // Request stage.
  pacc_pkg::req_t       req_r;
  pacc_pkg::slot_t      slot_r;
  logic                 range_ok_r;
  pacc_pkg::slot_t      in_slot;
  logic                 in_range_ok;

  // Evaluation.
  pacc_pkg::settings_t  fresh;
  pacc_pkg::settings_t  old_set;
  logic                 taken;
  logic                 match;
  pacc_pkg::resp_t      resp;
  pacc_pkg::resp_t      out_data_r;
  pacc_pkg::set_wr_t    set_wr;
  pacc_pkg::own_wr_t    own_wr;

  // The evaluation stage moves on when the result register is free or draining.
  assign pipe_adv = !out_valid_r || !out_stall;
  assign in_stall = v_r && !pipe_adv;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = v_r && pipe_adv;

  // Range check and slot index of the incoming request.
  assign in_range_ok = ({1'b0, in_data.port_index} < 5'(NUM_PORTS)) &&
                       ({1'b0, in_data.pin_index} < 6'(PINS_PER_PORT));
  assign in_slot = pacc_pkg::slot_t'(pacc_pkg::slot_t'(in_data.port_index) *
                                     pacc_pkg::slot_t'(PINS_PER_PORT)) +
                   pacc_pkg::slot_t'(in_data.pin_index);

  always_comb begin
    v_nxt = v_r;
    if (in_acc) begin
      v_nxt = 1'b1;
    end else if (pipe_adv) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r      <= in_data;
      slot_r     <= in_slot;
      range_ok_r <= in_range_ok;
    end
  end

  // Settings store, read as the request enters.
  pacc_settings_mem #(
    .DEPTH (NUM_SLOTS)
  ) u_settings (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_slot (in_slot),
    .wr      (set_wr),
    .rd_data (old_set)
  );

  // Ownership bits, read at the slot under evaluation.
  pacc_owner_bits #(
    .DEPTH (NUM_SLOTS)
  ) u_owner (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_slot (slot_r),
    .wr      (own_wr),
    .taken   (taken)
  );

  // Compare the new settings against the stored ones; the AF word only
  // counts when the new request is in alternate-function mode.
  always_comb begin
    fresh.af    = req_r.alt_function_word;
    fresh.pull  = req_r.pull_select;
    fresh.speed = req_r.output_speed;
    fresh.otype = req_r.output_type;
    fresh.mode  = req_r.pin_mode;
    if (req_r.pin_mode == pacc_pkg::MODE_ALT) begin
      match = (old_set == fresh);
    end else begin
      match = (old_set[pacc_pkg::BASE_SET_W-1:0] == fresh[pacc_pkg::BASE_SET_W-1:0]);
    end
  end

  // Decide the result and the state update.
  always_comb begin
    resp.status    = pacc_pkg::ST_OK;
    resp.apply_now = 1'b0;
    set_wr.en      = 1'b0;
    set_wr.slot    = slot_r;
    set_wr.data    = fresh;
    own_wr.en      = 1'b0;
    own_wr.slot    = slot_r;
    own_wr.value   = 1'b0;
    priority if (!range_ok_r) begin
      resp.status = pacc_pkg::ST_RANGE;
    end else if (req_r.operation == pacc_pkg::OP_RELEASE) begin
      own_wr.en    = fire;
      own_wr.value = 1'b0;
    end else if (taken) begin
      if (!match) begin
        resp.status = pacc_pkg::ST_CONFLICT;
      end
    end else begin
      resp.apply_now = 1'b1;
      set_wr.en      = fire;
      own_wr.en      = fire;
      own_wr.value   = 1'b1;
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pipe_adv) begin
      out_valid_nxt = v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A fresh allocation is always a success.
  a_apply_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.apply_now || out_data.status == pacc_pkg::ST_OK))
    else $error("apply_now set on a failing result");

  // Input is held back only by a stalled, full result register.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && v_r))
    else $error("input stalled without a blocked result");

  // An out-of-range request never touches the state.
  a_range_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (own_wr.en || set_wr.en) |-> range_ok_r)
    else $error("state written for an out-of-range request");

  // A held evaluation stage keeps its request.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && !pipe_adv) |=> (v_r && $stable(req_r) && $stable(slot_r)))
    else $error("request under evaluation changed while stalled");

endmodule

`default_nettype wire
